// ----- hw/rtl/c6502d_pkg.sv -----
// types, constants and decode table for the 6502 instruction stream decoder
package c6502d_pkg;

  // addressing modes
  localparam logic [3:0] AM_ACC = 4'd0;
  localparam logic [3:0] AM_ABS = 4'd1;
  localparam logic [3:0] AM_ABX = 4'd2;
  localparam logic [3:0] AM_ABY = 4'd3;
  localparam logic [3:0] AM_IMP = 4'd4;
  localparam logic [3:0] AM_IMM = 4'd5;
  localparam logic [3:0] AM_IND = 4'd6;
  localparam logic [3:0] AM_IZX = 4'd7;
  localparam logic [3:0] AM_IZY = 4'd8;
  localparam logic [3:0] AM_REL = 4'd9;
  localparam logic [3:0] AM_ZP  = 4'd10;
  localparam logic [3:0] AM_ZPX = 4'd11;
  localparam logic [3:0] AM_ZPY = 4'd12;

  typedef struct packed {
    logic [7:0] rom_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] instr_address;
    logic [7:0]  opcode_byte;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    logic [6:0]  mnemonic_id;
    logic [3:0]  addr_mode;
    logic [1:0]  instr_length;
    logic        truncated;
    logic        end_of_rom;
  } out_item_t;

  // mnemonic and mode for every opcode, packed as {mnemonic, mode}
  localparam logic [10:0] DECODE_TAB [256] = '{
    {7'd0,AM_IMP},{7'd1,AM_IZX},{7'd2,AM_IMP},{7'd3,AM_IZX},
    {7'd4,AM_ZP},{7'd1,AM_ZP},{7'd5,AM_ZP},{7'd3,AM_ZP},
    {7'd6,AM_IMP},{7'd1,AM_IMM},{7'd5,AM_ACC},{7'd7,AM_IMM},
    {7'd4,AM_ABS},{7'd1,AM_ABS},{7'd5,AM_ABS},{7'd3,AM_ABS},
    {7'd8,AM_REL},{7'd1,AM_IZY},{7'd2,AM_IMP},{7'd3,AM_IZY},
    {7'd4,AM_ZPX},{7'd1,AM_ZPX},{7'd5,AM_ZPX},{7'd3,AM_ZPX},
    {7'd9,AM_IMP},{7'd1,AM_ABY},{7'd4,AM_ACC},{7'd3,AM_ABY},
    {7'd4,AM_ABX},{7'd1,AM_ABX},{7'd5,AM_ABX},{7'd3,AM_ABX},
    {7'd10,AM_ABS},{7'd11,AM_IZX},{7'd2,AM_IMP},{7'd12,AM_IZX},
    {7'd13,AM_ZP},{7'd11,AM_ZP},{7'd14,AM_ZP},{7'd12,AM_ZP},
    {7'd15,AM_IMP},{7'd11,AM_IMM},{7'd14,AM_ACC},{7'd7,AM_IMM},
    {7'd13,AM_ABS},{7'd11,AM_ABS},{7'd14,AM_ABS},{7'd12,AM_ABS},
    {7'd16,AM_REL},{7'd11,AM_IZY},{7'd2,AM_IMP},{7'd12,AM_IZY},
    {7'd4,AM_ZPX},{7'd11,AM_ZPX},{7'd14,AM_ZPX},{7'd12,AM_ZPX},
    {7'd17,AM_IMP},{7'd11,AM_ABY},{7'd4,AM_ACC},{7'd12,AM_ABY},
    {7'd4,AM_ABX},{7'd11,AM_ABX},{7'd14,AM_ABX},{7'd12,AM_ABX},
    {7'd18,AM_IMP},{7'd19,AM_IZX},{7'd2,AM_IMP},{7'd20,AM_IZX},
    {7'd4,AM_ZP},{7'd19,AM_ZP},{7'd21,AM_ZP},{7'd20,AM_ZP},
    {7'd22,AM_IMP},{7'd19,AM_IMM},{7'd21,AM_ACC},{7'd23,AM_IMM},
    {7'd24,AM_ABS},{7'd19,AM_ABS},{7'd21,AM_ABS},{7'd20,AM_ABS},
    {7'd25,AM_REL},{7'd19,AM_IZY},{7'd2,AM_IMP},{7'd20,AM_IZY},
    {7'd4,AM_ZPX},{7'd19,AM_ZPX},{7'd21,AM_ZPX},{7'd20,AM_ZPX},
    {7'd26,AM_IMP},{7'd19,AM_ABY},{7'd4,AM_ACC},{7'd20,AM_ABY},
    {7'd4,AM_ABX},{7'd19,AM_ABX},{7'd21,AM_ABX},{7'd20,AM_ABX},
    {7'd27,AM_IMP},{7'd28,AM_IZX},{7'd2,AM_IMP},{7'd29,AM_IZX},
    {7'd4,AM_ZP},{7'd28,AM_ZP},{7'd30,AM_ZP},{7'd29,AM_ZP},
    {7'd31,AM_IMP},{7'd28,AM_IMM},{7'd30,AM_ACC},{7'd32,AM_IMM},
    {7'd24,AM_IND},{7'd28,AM_ABS},{7'd30,AM_ABS},{7'd29,AM_ABS},
    {7'd33,AM_REL},{7'd28,AM_IZY},{7'd2,AM_IMP},{7'd29,AM_IZY},
    {7'd4,AM_ZPX},{7'd28,AM_ZPX},{7'd30,AM_ZPX},{7'd29,AM_ZPX},
    {7'd34,AM_IMP},{7'd28,AM_ABY},{7'd4,AM_ACC},{7'd29,AM_ABY},
    {7'd4,AM_ABX},{7'd28,AM_ABX},{7'd30,AM_ABX},{7'd29,AM_ABX},
    {7'd4,AM_IMM},{7'd35,AM_IZX},{7'd4,AM_IMM},{7'd36,AM_IZX},
    {7'd37,AM_ZP},{7'd35,AM_ZP},{7'd38,AM_ZP},{7'd36,AM_ZP},
    {7'd39,AM_IMP},{7'd4,AM_IMM},{7'd40,AM_IMP},{7'd41,AM_IMM},
    {7'd37,AM_ABS},{7'd35,AM_ABS},{7'd38,AM_ABS},{7'd36,AM_ABS},
    {7'd42,AM_REL},{7'd35,AM_IZY},{7'd2,AM_IMP},{7'd43,AM_IZY},
    {7'd37,AM_ZPX},{7'd35,AM_ZPX},{7'd38,AM_ZPY},{7'd36,AM_ZPY},
    {7'd44,AM_IMP},{7'd35,AM_ABY},{7'd45,AM_IMP},{7'd46,AM_ABY},
    {7'd47,AM_ABX},{7'd35,AM_ABX},{7'd48,AM_ABY},{7'd43,AM_ABY},
    {7'd49,AM_IMM},{7'd50,AM_IZX},{7'd51,AM_IMM},{7'd52,AM_IZX},
    {7'd49,AM_ZP},{7'd50,AM_ZP},{7'd51,AM_ZP},{7'd52,AM_ZP},
    {7'd53,AM_IMP},{7'd50,AM_IMM},{7'd54,AM_IMP},{7'd52,AM_IMM},
    {7'd49,AM_ABS},{7'd50,AM_ABS},{7'd51,AM_ABS},{7'd52,AM_ABS},
    {7'd55,AM_REL},{7'd50,AM_IZY},{7'd2,AM_IMP},{7'd52,AM_IZY},
    {7'd49,AM_ZPX},{7'd50,AM_ZPX},{7'd51,AM_ZPY},{7'd52,AM_ZPY},
    {7'd56,AM_IMP},{7'd50,AM_ABY},{7'd57,AM_IMP},{7'd58,AM_ABY},
    {7'd49,AM_ABX},{7'd50,AM_ABX},{7'd51,AM_ABY},{7'd52,AM_ABY},
    {7'd59,AM_IMM},{7'd60,AM_IZX},{7'd4,AM_IMM},{7'd61,AM_IZX},
    {7'd59,AM_ZP},{7'd60,AM_ZP},{7'd62,AM_ZP},{7'd61,AM_ZP},
    {7'd63,AM_IMP},{7'd60,AM_IMM},{7'd64,AM_IMP},{7'd65,AM_IMM},
    {7'd59,AM_ABS},{7'd60,AM_ABS},{7'd62,AM_ABS},{7'd61,AM_ABS},
    {7'd66,AM_REL},{7'd60,AM_IZY},{7'd2,AM_IMP},{7'd61,AM_IZY},
    {7'd4,AM_ZPX},{7'd60,AM_ZPX},{7'd62,AM_ZPX},{7'd61,AM_ZPX},
    {7'd67,AM_IMP},{7'd60,AM_ABY},{7'd4,AM_ACC},{7'd61,AM_ABY},
    {7'd4,AM_ABX},{7'd60,AM_ABX},{7'd62,AM_ABX},{7'd61,AM_ABX},
    {7'd68,AM_IMM},{7'd69,AM_IZX},{7'd4,AM_IMM},{7'd70,AM_IZX},
    {7'd68,AM_ZP},{7'd69,AM_ZP},{7'd71,AM_ZP},{7'd70,AM_ZP},
    {7'd72,AM_IMP},{7'd69,AM_IMM},{7'd4,AM_ACC},{7'd69,AM_IMM},
    {7'd68,AM_ABS},{7'd69,AM_ABS},{7'd71,AM_ABS},{7'd70,AM_ABS},
    {7'd73,AM_REL},{7'd69,AM_IZY},{7'd2,AM_IMP},{7'd70,AM_IZY},
    {7'd4,AM_ZPX},{7'd69,AM_ZPX},{7'd71,AM_ZPX},{7'd70,AM_ZPX},
    {7'd74,AM_IMP},{7'd69,AM_ABY},{7'd4,AM_ACC},{7'd70,AM_ABY},
    {7'd4,AM_ABX},{7'd69,AM_ABX},{7'd71,AM_ABX},{7'd70,AM_ABX}
  };

  // instruction length implied by an addressing mode
  function automatic logic [1:0] mode_len(input logic [3:0] mode);
    logic [1:0] len;
    case (mode)
      AM_ABS, AM_ABX, AM_ABY, AM_IND: len = 2'd3;
      AM_ACC, AM_IMP:                 len = 2'd1;
      default:                        len = 2'd2;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/cpu6502_instruction_stream_decoder.sv -----
// Splits a stream of 6502 ROM bytes into decoded instruction records.
// One byte is taken per cycle, with no bubbles, while the output register is
// free or draining and reset has cleared the state: each byte reads and writes
// back one entry of a one-deep state memory, whose write is forwarded to the
// next read. A record passes the stage 1 register, then an output register
// that holds it while the result side stalls. The last byte of an image closes
// any open instruction (marked truncated) and restarts at address 0.
module cpu6502_instruction_stream_decoder (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  c6502d_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output c6502d_pkg::out_item_t  out_data
);

  // one state entry: pending count, opcode, low operand, start address
  typedef struct packed {
    logic [1:0]  pending;
    logic [7:0]  opcode;
    logic [7:0]  op_low;
    logic [15:0] start;
  } entry_t;

  entry_t     mem [1];
  entry_t     rd_q, wr_d, wr_q, cur;
  logic       wr_vld;
  logic       init_done;
  logic [15:0] byte_address;

  logic       s1_valid;
  c6502d_pkg::in_item_t s1_item;
  logic [15:0] s1_addr;

  logic       emit;
  c6502d_pkg::out_item_t rec;

  logic       adv;
  logic       take;

  // advance whenever the output register is free or draining
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv || !init_done;
  assign take = in_valid && !in_stall;

  // state memory, read and write, with a registered read
  always_ff @(posedge clk) begin
    rd_q <= mem[0];
    if (rst || !init_done) begin
      mem[0] <= '0;
    end else if (wr_vld) begin
      mem[0] <= wr_d;
    end
  end

  // forwarding of the write issued last cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q <= '0;
      init_done <= 1'b0;
    end else begin
      init_done <= 1'b1;
      if (wr_vld) begin
        wr_q <= wr_d;
      end
    end
  end

  logic fwd;
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b1;
    end else begin
      fwd <= wr_vld || !init_done;
    end
  end
  assign cur = fwd ? wr_q : rd_q;

  // stage 1 capture and byte address
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byte_address <= '0;
    end else if (adv) begin
      s1_valid <= take;
      if (take) begin
        byte_address <= in_data.last_byte ? 16'd0 : byte_address + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && take) begin
      s1_item <= in_data;
      s1_addr <= byte_address;
    end
  end

  // decode and state update
  always_comb begin
    logic [10:0] d;
    logic [7:0]  op;
    logic [1:0]  len;
    logic        last;
    logic [7:0]  b;
    d = '0;
    b = s1_item.rom_byte;
    last = s1_item.last_byte;
    wr_d = cur;
    emit = 1'b0;
    rec = '0;
    op = (cur.pending == 2'd0) ? b : cur.opcode;
    d = c6502d_pkg::DECODE_TAB[op];
    len = c6502d_pkg::mode_len(d[3:0]);
    rec.opcode_byte = op;
    rec.mnemonic_id = d[10:4];
    rec.addr_mode = d[3:0];
    rec.instr_length = len;
    rec.end_of_rom = last;
    if (cur.pending == 2'd0) begin
      rec.instr_address = s1_addr;
      if (len == 2'd1) begin
        emit = 1'b1;
      end else if (last) begin
        emit = 1'b1;
        rec.truncated = 1'b1;
      end else begin
        wr_d.opcode = b;
        wr_d.start = s1_addr;
        wr_d.op_low = '0;
        wr_d.pending = len - 2'd1;
      end
    end else begin
      rec.instr_address = cur.start;
      if (cur.pending == 2'd1) begin
        emit = 1'b1;
        if (len == 2'd3) begin
          rec.operand_low = cur.op_low;
          rec.operand_high = b;
        end else begin
          rec.operand_low = b;
        end
        wr_d.pending = 2'd0;
      end else begin
        wr_d.op_low = b;
        wr_d.pending = 2'd1;
        if (last) begin
          emit = 1'b1;
          rec.truncated = 1'b1;
          rec.operand_low = b;
        end
      end
    end
    if (last) begin
      wr_d.pending = 2'd0;
    end
  end

  assign wr_vld = s1_valid && adv;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid && emit) begin
      out_data <= rec;
    end
  end

endmodule

// ----- hw/rtl/c6502d_checker.sv -----
// port-level checks for the instruction stream decoder, bound to the top level
module c6502d_assert (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input c6502d_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input c6502d_pkg::out_item_t out_data
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // length agrees with mode
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.instr_length == c6502d_pkg::mode_len(out_data.addr_mode))
    else $error("length does not match mode");

  // truncated records close the image
  a_trunc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.truncated |-> out_data.end_of_rom && out_data.instr_length != 2'd1)
    else $error("bad truncated record");

  // missing high operand is zero for two byte instructions
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.instr_length != 2'd3 |-> out_data.operand_high == 8'd0)
    else $error("operand high not zero");

endmodule

bind cpu6502_instruction_stream_decoder c6502d_assert u_checker (.*);

// ----- tb/sv/c6502d_checker.sv -----
// checker: predicts decoded instruction records from accepted rom bytes and compares
`timescale 1ns / 100ps
module c6502d_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  c6502d_pkg::in_item_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  c6502d_pkg::out_item_t out_data,
  output int                    fail_count,
  output int                    pending_records,
  output int                    record_count
);
  import c6502d_pkg::*;

  // mnemonic indexes used by the predictor table
  typedef enum logic [6:0] {
    BRK, ORA, KIL, SLO, NOP, ASL, PHP, ANC, BPL, CLC, JSR, ANDI, RLA, BIT, ROL, PLP,
    BMI, SEC, RTI, EOR, SRE, LSR, PHA, ALR, JMP, BVC, CLI, RTS, ADC, RRA, ROR, PLA,
    ARR, BVS, SEI, STA, SAX, STY, STX, DEY, TXA, XAA, BCC, AHX, TYA, TXS, TAS, SHY,
    SHX, LDY, LDA, LDX, LAX, TAY, TAX, BCS, CLV, TSX, LAS, CPY, CMP, DCP, DEC, INY,
    DEX, AXS, BNE, CLD, CPX, SBC, ISC, INC, INX, BEQ, SED
  } mnem_e;

  logic [6:0] op_mnem [256];
  logic [3:0] op_mode [256];

  out_item_t record_q[$];
  logic [15:0] pc;
  logic [1:0]  need;
  logic [7:0]  op_hold;
  logic [7:0]  lo_hold;
  logic [15:0] start_hold;

  // fill one row of eight opcodes
  task automatic row(input int base, input mnem_e m0, input logic [3:0] a0,
                     input mnem_e m1, input logic [3:0] a1, input mnem_e m2,
                     input logic [3:0] a2, input mnem_e m3, input logic [3:0] a3,
                     input mnem_e m4, input logic [3:0] a4, input mnem_e m5,
                     input logic [3:0] a5, input mnem_e m6, input logic [3:0] a6,
                     input mnem_e m7, input logic [3:0] a7);
    op_mnem[base]   = m0; op_mode[base]   = a0;
    op_mnem[base+1] = m1; op_mode[base+1] = a1;
    op_mnem[base+2] = m2; op_mode[base+2] = a2;
    op_mnem[base+3] = m3; op_mode[base+3] = a3;
    op_mnem[base+4] = m4; op_mode[base+4] = a4;
    op_mnem[base+5] = m5; op_mode[base+5] = a5;
    op_mnem[base+6] = m6; op_mode[base+6] = a6;
    op_mnem[base+7] = m7; op_mode[base+7] = a7;
  endtask

  initial begin
    row(8'h00, BRK,AM_IMP, ORA,AM_IZX, KIL,AM_IMP, SLO,AM_IZX, NOP,AM_ZP, ORA,AM_ZP, ASL,AM_ZP, SLO,AM_ZP);
    row(8'h08, PHP,AM_IMP, ORA,AM_IMM, ASL,AM_ACC, ANC,AM_IMM, NOP,AM_ABS, ORA,AM_ABS, ASL,AM_ABS, SLO,AM_ABS);
    row(8'h10, BPL,AM_REL, ORA,AM_IZY, KIL,AM_IMP, SLO,AM_IZY, NOP,AM_ZPX, ORA,AM_ZPX, ASL,AM_ZPX, SLO,AM_ZPX);
    row(8'h18, CLC,AM_IMP, ORA,AM_ABY, NOP,AM_ACC, SLO,AM_ABY, NOP,AM_ABX, ORA,AM_ABX, ASL,AM_ABX, SLO,AM_ABX);
    row(8'h20, JSR,AM_ABS, ANDI,AM_IZX, KIL,AM_IMP, RLA,AM_IZX, BIT,AM_ZP, ANDI,AM_ZP, ROL,AM_ZP, RLA,AM_ZP);
    row(8'h28, PLP,AM_IMP, ANDI,AM_IMM, ROL,AM_ACC, ANC,AM_IMM, BIT,AM_ABS, ANDI,AM_ABS, ROL,AM_ABS, RLA,AM_ABS);
    row(8'h30, BMI,AM_REL, ANDI,AM_IZY, KIL,AM_IMP, RLA,AM_IZY, NOP,AM_ZPX, ANDI,AM_ZPX, ROL,AM_ZPX, RLA,AM_ZPX);
    row(8'h38, SEC,AM_IMP, ANDI,AM_ABY, NOP,AM_ACC, RLA,AM_ABY, NOP,AM_ABX, ANDI,AM_ABX, ROL,AM_ABX, RLA,AM_ABX);
    row(8'h40, RTI,AM_IMP, EOR,AM_IZX, KIL,AM_IMP, SRE,AM_IZX, NOP,AM_ZP, EOR,AM_ZP, LSR,AM_ZP, SRE,AM_ZP);
    row(8'h48, PHA,AM_IMP, EOR,AM_IMM, LSR,AM_ACC, ALR,AM_IMM, JMP,AM_ABS, EOR,AM_ABS, LSR,AM_ABS, SRE,AM_ABS);
    row(8'h50, BVC,AM_REL, EOR,AM_IZY, KIL,AM_IMP, SRE,AM_IZY, NOP,AM_ZPX, EOR,AM_ZPX, LSR,AM_ZPX, SRE,AM_ZPX);
    row(8'h58, CLI,AM_IMP, EOR,AM_ABY, NOP,AM_ACC, SRE,AM_ABY, NOP,AM_ABX, EOR,AM_ABX, LSR,AM_ABX, SRE,AM_ABX);
    row(8'h60, RTS,AM_IMP, ADC,AM_IZX, KIL,AM_IMP, RRA,AM_IZX, NOP,AM_ZP, ADC,AM_ZP, ROR,AM_ZP, RRA,AM_ZP);
    row(8'h68, PLA,AM_IMP, ADC,AM_IMM, ROR,AM_ACC, ARR,AM_IMM, JMP,AM_IND, ADC,AM_ABS, ROR,AM_ABS, RRA,AM_ABS);
    row(8'h70, BVS,AM_REL, ADC,AM_IZY, KIL,AM_IMP, RRA,AM_IZY, NOP,AM_ZPX, ADC,AM_ZPX, ROR,AM_ZPX, RRA,AM_ZPX);
    row(8'h78, SEI,AM_IMP, ADC,AM_ABY, NOP,AM_ACC, RRA,AM_ABY, NOP,AM_ABX, ADC,AM_ABX, ROR,AM_ABX, RRA,AM_ABX);
    row(8'h80, NOP,AM_IMM, STA,AM_IZX, NOP,AM_IMM, SAX,AM_IZX, STY,AM_ZP, STA,AM_ZP, STX,AM_ZP, SAX,AM_ZP);
    row(8'h88, DEY,AM_IMP, NOP,AM_IMM, TXA,AM_IMP, XAA,AM_IMM, STY,AM_ABS, STA,AM_ABS, STX,AM_ABS, SAX,AM_ABS);
    row(8'h90, BCC,AM_REL, STA,AM_IZY, KIL,AM_IMP, AHX,AM_IZY, STY,AM_ZPX, STA,AM_ZPX, STX,AM_ZPY, SAX,AM_ZPY);
    row(8'h98, TYA,AM_IMP, STA,AM_ABY, TXS,AM_IMP, TAS,AM_ABY, SHY,AM_ABX, STA,AM_ABX, SHX,AM_ABY, AHX,AM_ABY);
    row(8'hA0, LDY,AM_IMM, LDA,AM_IZX, LDX,AM_IMM, LAX,AM_IZX, LDY,AM_ZP, LDA,AM_ZP, LDX,AM_ZP, LAX,AM_ZP);
    row(8'hA8, TAY,AM_IMP, LDA,AM_IMM, TAX,AM_IMP, LAX,AM_IMM, LDY,AM_ABS, LDA,AM_ABS, LDX,AM_ABS, LAX,AM_ABS);
    row(8'hB0, BCS,AM_REL, LDA,AM_IZY, KIL,AM_IMP, LAX,AM_IZY, LDY,AM_ZPX, LDA,AM_ZPX, LDX,AM_ZPY, LAX,AM_ZPY);
    row(8'hB8, CLV,AM_IMP, LDA,AM_ABY, TSX,AM_IMP, LAS,AM_ABY, LDY,AM_ABX, LDA,AM_ABX, LDX,AM_ABY, LAX,AM_ABY);
    row(8'hC0, CPY,AM_IMM, CMP,AM_IZX, NOP,AM_IMM, DCP,AM_IZX, CPY,AM_ZP, CMP,AM_ZP, DEC,AM_ZP, DCP,AM_ZP);
    row(8'hC8, INY,AM_IMP, CMP,AM_IMM, DEX,AM_IMP, AXS,AM_IMM, CPY,AM_ABS, CMP,AM_ABS, DEC,AM_ABS, DCP,AM_ABS);
    row(8'hD0, BNE,AM_REL, CMP,AM_IZY, KIL,AM_IMP, DCP,AM_IZY, NOP,AM_ZPX, CMP,AM_ZPX, DEC,AM_ZPX, DCP,AM_ZPX);
    row(8'hD8, CLD,AM_IMP, CMP,AM_ABY, NOP,AM_ACC, DCP,AM_ABY, NOP,AM_ABX, CMP,AM_ABX, DEC,AM_ABX, DCP,AM_ABX);
    row(8'hE0, CPX,AM_IMM, SBC,AM_IZX, NOP,AM_IMM, ISC,AM_IZX, CPX,AM_ZP, SBC,AM_ZP, INC,AM_ZP, ISC,AM_ZP);
    row(8'hE8, INX,AM_IMP, SBC,AM_IMM, NOP,AM_ACC, SBC,AM_IMM, CPX,AM_ABS, SBC,AM_ABS, INC,AM_ABS, ISC,AM_ABS);
    row(8'hF0, BEQ,AM_REL, SBC,AM_IZY, KIL,AM_IMP, ISC,AM_IZY, NOP,AM_ZPX, SBC,AM_ZPX, INC,AM_ZPX, ISC,AM_ZPX);
    row(8'hF8, SED,AM_IMP, SBC,AM_ABY, NOP,AM_ACC, ISC,AM_ABY, NOP,AM_ABX, SBC,AM_ABX, INC,AM_ABX, ISC,AM_ABX);
  end

  // bytes an instruction occupies, from its addressing mode
  function automatic logic [1:0] length_of(input logic [7:0] op);
    logic [1:0] n;
    case (op_mode[op])
      AM_ACC, AM_IMP:                 n = 2'd1;
      AM_ABS, AM_ABX, AM_ABY, AM_IND: n = 2'd3;
      default:                        n = 2'd2;
    endcase
    return n;
  endfunction

  function automatic out_item_t make_record(input logic [15:0] a, input logic [7:0] op,
                                            input logic [7:0] lo, input logic [7:0] hi,
                                            input logic trunc, input logic eor);
    out_item_t r;
    r.instr_address = a;
    r.opcode_byte   = op;
    r.operand_low   = lo;
    r.operand_high  = hi;
    r.mnemonic_id   = op_mnem[op];
    r.addr_mode     = op_mode[op];
    r.instr_length  = length_of(op);
    r.truncated     = trunc;
    r.end_of_rom    = eor;
    return r;
  endfunction

  // advance the instruction splitter by one rom byte
  task automatic split_byte(input in_item_t it);
    logic [15:0] here;
    logic [1:0]  len;
    here = pc;
    pc   = pc + 16'd1;
    if (need == 2'd0) begin
      len = length_of(it.rom_byte);
      if (len == 2'd1) begin
        record_q.push_back(make_record(here, it.rom_byte, 8'd0, 8'd0, 1'b0, it.last_byte));
      end else if (it.last_byte) begin
        record_q.push_back(make_record(here, it.rom_byte, 8'd0, 8'd0, 1'b1, 1'b1));
      end else begin
        op_hold    = it.rom_byte;
        start_hold = here;
        lo_hold    = 8'd0;
        need       = len - 2'd1;
      end
    end else if (need == 2'd1) begin
      if (length_of(op_hold) == 2'd3)
        record_q.push_back(make_record(start_hold, op_hold, lo_hold, it.rom_byte, 1'b0,
                                       it.last_byte));
      else
        record_q.push_back(make_record(start_hold, op_hold, it.rom_byte, 8'd0, 1'b0,
                                       it.last_byte));
      need = 2'd0;
    end else begin
      lo_hold = it.rom_byte;
      need    = 2'd1;
      if (it.last_byte)
        record_q.push_back(make_record(start_hold, op_hold, it.rom_byte, 8'd0, 1'b1, 1'b1));
    end
    if (it.last_byte) begin
      pc   = 16'd0;
      need = 2'd0;
    end
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    out_item_t exp_rec;
    if (rst) begin
      pc = 16'd0; need = 2'd0; op_hold = 8'd0; lo_hold = 8'd0; start_hold = 16'd0;
      record_q.delete();
      fail_count   <= 0;
      record_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        record_count <= record_count + 1;
        if (record_q.size() == 0) begin
          $display("%0t: unexpected record, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_rec = record_q.pop_front();
          if (out_data !== exp_rec) begin
            $display("%0t: record mismatch, expected %h, actual %h", $time, exp_rec, out_data);
            $display("  addr %h/%h op %h/%h lo %h/%h hi %h/%h mn %0d/%0d mode %0d/%0d",
                     exp_rec.instr_address, out_data.instr_address, exp_rec.opcode_byte,
                     out_data.opcode_byte, exp_rec.operand_low, out_data.operand_low,
                     exp_rec.operand_high, out_data.operand_high, exp_rec.mnemonic_id,
                     out_data.mnemonic_id, exp_rec.addr_mode, out_data.addr_mode);
            $display("  len %0d/%0d trunc %b/%b eor %b/%b", exp_rec.instr_length,
                     out_data.instr_length, exp_rec.truncated, out_data.truncated,
                     exp_rec.end_of_rom, out_data.end_of_rom);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) split_byte(in_data);
    end
    pending_records <= record_q.size();
  end
endmodule

// ----- tb/sv/tb_top.sv -----
// testbench top: rom byte stimulus, reset, clock and verdict for the stream decoder
`timescale 1ns / 100ps
module tb_top;
  import c6502d_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending_records;
  int        record_count;
  int        byte_count = 0;
  int        image_count = 0;
  int        drain_cycles;
  bit        quiet_phase = 1'b0;

  always #4 clk = ~clk;

  cpu6502_instruction_stream_decoder uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  c6502d_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_records(pending_records),
    .record_count(record_count)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // result side stall pattern
  always @(negedge clk) begin
    int g;
    if (rst || quiet_phase) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      if ($urandom_range(0, 99) < 40) out_stall <= 1'b0;
    end else begin
      g = gap_len();
      if (g > 3) out_stall <= 1'b1;
      else if (g > 0 && $urandom_range(0, 1)) out_stall <= 1'b1;
    end
  end

  // present one rom byte and hold it until accepted; valid stays up for the next call
  task automatic send_byte(input logic [7:0] b, input logic last);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data  <= '{rom_byte: b, last_byte: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    byte_count++;
    if (last) image_count++;
    @(negedge clk);
  endtask

  // random opcode with random operands; the last one of an image may be cut short
  task automatic send_instr(input bit finish, input bit cut);
    logic [7:0] op;
    int n, k;
    op = 8'($urandom_range(0, 255));
    n  = int'(chk.length_of(op));
    if (finish && cut && n > 1) n = $urandom_range(1, n - 1);
    send_byte(op, finish && n == 1);
    for (k = 1; k < n; k++) send_byte(8'($urandom_range(0, 255)), finish && k == n - 1);
  endtask

  initial begin
    int j, len;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: lengths, extremes, truncations, one-byte nops
    send_byte(8'h00, 1'b0);                               // brk
    send_byte(8'h6C, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h96, 1'b0); send_byte(8'hAA, 1'b0);       // zpy
    send_byte(8'h1A, 1'b0); send_byte(8'hEA, 1'b0);
    send_byte(8'hEB, 1'b0); send_byte(8'h55, 1'b0);
    send_byte(8'h20, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h20, 1'b0); send_byte(8'h34, 1'b1);       // cut after one operand
    send_byte(8'hA9, 1'b1);                               // cut at opcode
    send_byte(8'h20, 1'b1);
    send_byte(8'hEA, 1'b1);                               // complete one byte at end
    send_byte(8'hD0, 1'b0); send_byte(8'hFE, 1'b1);       // complete two bytes at end
    in_valid <= 1'b0;

    // wait for every record before the random part
    while (pending_records != 0) @(negedge clk);

    // random images
    while (byte_count < 560) begin
      len = $urandom_range(0, 99) < 90 ? $urandom_range(1, 20) : $urandom_range(20, 120);
      for (j = 1; j < len; j++) send_instr(1'b0, 1'b0);
      send_instr(1'b1, $urandom_range(0, 2) == 0);
      if (image_count % 6 == 0) quiet_phase = ~quiet_phase;
    end
    quiet_phase = 1'b0;

    // one more image, ending mid-instruction unless its last opcode is one byte long
    for (j = 0; j < 40; j++) send_instr(1'b0, 1'b0);
    send_instr(1'b1, 1'b1);
    in_valid <= 1'b0;

    // drain
    drain_cycles = 0;
    while (pending_records != 0 && drain_cycles < 100000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (20) @(negedge clk);
    $display("covered %0d rom bytes in %0d images, %0d records checked",
             byte_count, image_count, record_count);
    $display("including all lengths, truncated endings and stalls on both sides");
    if (fail_count == 0 && pending_records == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
